// ----- rtl/core/pbrt_pkg.sv -----
package pbrt_pkg;

    // Defaults of the top-level parameters.
    localparam int BLOCK_SHIFT_DEF = 14;
    localparam int MAX_BLOCKS_DEF  = 256;

    // Fixed field widths.
    localparam int PIECE_BYTES_W = 23;
    localparam int OFFSET_W      = 24;
    localparam int LENGTH_W      = 16;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 40;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_PIECE_BYTES    = 1'b0;
    localparam logic REG_PIECE_VERIFIED = 1'b1;

    // Width of the session tag kept in each bitmap entry.
    localparam int EPOCH_W = 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 2'd3;

    // Outcome of the request checks, carried from the check logic to the tracker.
    typedef struct packed {
        logic                reject;
        logic [OFFSET_W-1:0] block;
    } check_t;

endpackage

// ----- rtl/core/piece_block_receive_tracker_unit.sv -----
// Tracks which blocks of one piece have arrived and answers every block
// transfer with one status transfer (accepted, rejected, duplicate, or
// accepted with the piece complete) plus the count of blocks still missing.
// Each item is first checked and its bitmap entry read from the tag memory,
// then the entry and the counters are updated and the output register is
// loaded. The input takes no new item while one is still waiting for its
// update. A result left waiting in the output register holds up the next
// update. Each bitmap entry stores a session tag; a new piece session bumps
// the tag instead of clearing the bitmap. After reset, and after every
// (2**EPOCH_W - 1)th completed piece, a clearing pass rewrites every entry of
// the tag memory and holds off input transfers. Configuration writes are
// taken at any time, but belong between items, with no item in flight.
module piece_block_receive_tracker_unit
    import pbrt_pkg::*;
#(
    parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1),
    localparam int OUT_TDATA_W = ((STATUS_W + CNT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [23:0] block_offset, [39:24] block_length
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [CNT_W+1:2] remaining_blocks, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [OFFSET_W-1:0] BS = OFFSET_W'(1) << BLOCK_SHIFT;
    localparam logic [EPOCH_W-1:0]  EPOCH_MAX = '1;

    // Configuration registers.
    logic [PIECE_BYTES_W-1:0] piece_bytes_reg;
    logic                     piece_verified_reg;
    logic                     cfg_wr;

    // Tracking state.
    logic                     tracking_reg;
    logic [CNT_W-1:0]         missing_reg;
    logic [EPOCH_W-1:0]       epoch_reg;
    logic                     sweep_reg;
    logic [IDX_W-1:0]         sweep_idx_reg;

    // Item in flight between the memory read and the update.
    logic                     s1_valid_reg;
    logic                     s1_reject_reg;
    logic [IDX_W-1:0]         s1_idx_reg;

    // Output register.
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [CNT_W-1:0]         out_remain_reg;

    check_t                   chk;
    logic                     in_fire;
    logic                     s1_fire;
    logic [EPOCH_W-1:0]       rd_tag;

    logic [OFFSET_W-1:0]      bc_full;
    logic [CNT_W-1:0]         block_cnt;
    logic                     start;
    logic                     hit;
    logic [EPOCH_W-1:0]       cur_epoch;
    logic [CNT_W-1:0]         base_cnt;
    logic [CNT_W-1:0]         dec_cnt;
    logic                     set_entry;
    logic                     done_piece;
    logic [STATUS_W-1:0]      status_next;
    logic [CNT_W-1:0]         remain_next;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [EPOCH_W-1:0]       mem_wdata;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_bytes_reg    <= '0;
            piece_verified_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PIECE_BYTES)
            begin
                piece_bytes_reg <= pwdata[PIECE_BYTES_W-1:0];
            end
            else
            begin
                piece_verified_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PIECE_BYTES)
        begin
            prdata = PDATA_W'(piece_bytes_reg);
        end
        else
        begin
            prdata = PDATA_W'(piece_verified_reg);
        end
    end

    // ---------------------------------------------------------------
    // Request check and bitmap read
    // ---------------------------------------------------------------
    pbrt_check #(
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_check (
        .block_offset   (s_axis_tdata[OFFSET_W-1:0]),
        .block_length   (s_axis_tdata[OFFSET_W+LENGTH_W-1:OFFSET_W]),
        .piece_bytes    (piece_bytes_reg),
        .piece_verified (piece_verified_reg),
        .check          (chk)
    );

    assign s_axis_tready = !s1_valid_reg && !sweep_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);

    pbrt_tag_mem #(
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (EPOCH_W)
    ) u_tag_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (in_fire),
        .rd_addr (chk.block[IDX_W-1:0]),
        .rd_data (rd_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reject_reg <= chk.reject;
            s1_idx_reg    <= chk.block[IDX_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Update
    // ---------------------------------------------------------------
    always_comb
    begin
        bc_full   = (OFFSET_W'(piece_bytes_reg) + (BS - OFFSET_W'(1))) >> BLOCK_SHIFT;
        block_cnt = (bc_full > OFFSET_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                      : bc_full[CNT_W-1:0];

        // An entry counts as set only if it carries the tag of the live session.
        start     = !tracking_reg;
        hit       = tracking_reg && (rd_tag == epoch_reg);
        cur_epoch = start ? epoch_reg + EPOCH_W'(1) : epoch_reg;
        base_cnt  = start ? block_cnt : missing_reg;
        dec_cnt   = (base_cnt != '0) ? base_cnt - CNT_W'(1) : '0;

        set_entry  = !s1_reject_reg && !hit;
        done_piece = set_entry && (dec_cnt == '0);

        if (s1_reject_reg)
        begin
            status_next = ST_REJECTED;
            remain_next = tracking_reg ? missing_reg : '0;
        end
        else if (hit)
        begin
            status_next = ST_DUPLICATE;
            remain_next = missing_reg;
        end
        else if (done_piece)
        begin
            status_next = ST_COMPLETE;
            remain_next = '0;
        end
        else
        begin
            status_next = ST_ACCEPTED;
            remain_next = dec_cnt;
        end
    end

    always_comb
    begin
        if (sweep_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_fire && set_entry;
            mem_waddr = s1_idx_reg;
            mem_wdata = cur_epoch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg  <= 1'b0;
            missing_reg   <= '0;
            epoch_reg     <= '0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end
        else
        begin
            if (sweep_reg)
            begin
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
                if (sweep_idx_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    sweep_reg <= 1'b0;
                end
            end

            if (s1_fire && set_entry)
            begin
                if (done_piece)
                begin
                    tracking_reg <= 1'b0;
                    missing_reg  <= '0;
                    // Tags are about to run out: wipe the memory and restart them.
                    if (cur_epoch == EPOCH_MAX)
                    begin
                        epoch_reg     <= '0;
                        sweep_reg     <= 1'b1;
                        sweep_idx_reg <= '0;
                    end
                    else
                    begin
                        epoch_reg <= cur_epoch;
                    end
                end
                else
                begin
                    tracking_reg <= 1'b1;
                    missing_reg  <= dec_cnt;
                    epoch_reg    <= cur_epoch;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg <= status_next;
            out_remain_reg <= remain_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_remain_reg, out_status_reg});

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_input_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !in_fire)
        else $error("input transfer taken during the clearing pass");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg)
        else $error("item in flight lost");

    a_complete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status_reg == ST_COMPLETE) |-> (out_remain_reg == '0))
        else $error("complete piece reports missing blocks");

    a_accepted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status_reg == ST_ACCEPTED) |-> (out_remain_reg != '0))
        else $error("accepted block reports zero missing blocks");

    a_tag_wrap_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && done_piece && cur_epoch == EPOCH_MAX) |=> (sweep_reg && epoch_reg == '0))
        else $error("tag wrap without clearing pass");

    a_idle_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        !tracking_reg |-> (missing_reg == '0))
        else $error("missing count left over after tracking ended");

endmodule

// ----- rtl/core/pbrt_check.sv -----
module pbrt_check
    import pbrt_pkg::*;
#(
    parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
)
(
    input  logic [OFFSET_W-1:0]      block_offset,
    input  logic [LENGTH_W-1:0]      block_length,
    input  logic [PIECE_BYTES_W-1:0] piece_bytes,
    input  logic                     piece_verified,
    output check_t                   check
);

    localparam logic [OFFSET_W-1:0] BS = OFFSET_W'(1) << BLOCK_SHIFT;

    logic [OFFSET_W-1:0] pb_ext;
    logic [OFFSET_W-1:0] rest;
    logic [OFFSET_W-1:0] expect_len;
    logic [OFFSET_W-1:0] blk;
    logic                in_range;
    logic                aligned;
    logic                blk_ok;
    logic                len_ok;

    always_comb
    begin
        pb_ext   = OFFSET_W'(piece_bytes);
        in_range = block_offset < pb_ext;
        aligned  = (block_offset & (BS - OFFSET_W'(1))) == '0;
        blk      = block_offset >> BLOCK_SHIFT;
        blk_ok   = blk < OFFSET_W'(MAX_BLOCKS);
        // The last block of the piece may be shorter than a full block.
        rest       = pb_ext - block_offset;
        expect_len = (rest < BS) ? rest : BS;
        len_ok     = OFFSET_W'(block_length) == expect_len;

        check.reject = piece_verified || !in_range || !aligned || !blk_ok || !len_ok;
        check.block  = blk;
    end

endmodule

// ----- rtl/core/pbrt_tag_mem.sv -----
module pbrt_tag_mem
    import pbrt_pkg::*;
#(
    parameter int DEPTH  = MAX_BLOCKS_DEF,
    parameter int ADDR_W = 8,
    parameter int DATA_W = EPOCH_W
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- dv/piece_block_receive_tracker_unit_tb.sv -----
`timescale 1ns / 100ps

module piece_block_receive_tracker_unit_tb;
    import pbrt_pkg::*;

    localparam int BLOCK_SHIFT = BLOCK_SHIFT_DEF;
    localparam int MAX_BLOCKS  = MAX_BLOCKS_DEF;
    localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int OUT_W       = ((STATUS_W + CNT_W + 7) / 8) * 8;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    remaining;
    } block_status_t;

    // Predicts the status of every block transfer and checks the results in order.
    class block_tracker_sb;
        logic [PIECE_BYTES_W-1:0] piece_bytes;
        logic                     verified;
        logic [MAX_BLOCKS-1:0]    got_map;
        logic [CNT_W-1:0]         missing;
        logic                     active;
        block_status_t            status_due[$];
        int                       errors;

        function new();
            piece_bytes = '0;
            verified    = 1'b0;
            got_map     = '0;
            missing     = '0;
            active      = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic [PDATA_W-1:0] val);
            if (idx == REG_PIECE_BYTES)
                piece_bytes = val[PIECE_BYTES_W-1:0];
            else
                verified = val[0];
        endfunction

        function int unsigned piece_blocks();
            int unsigned n;
            n = (int'(piece_bytes) + BLOCK_BYTES - 1) >> BLOCK_SHIFT;
            return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
        endfunction

        function void note_block(logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] len);
            int unsigned   blk;
            int unsigned   stop;
            block_status_t due;
            blk  = off >> BLOCK_SHIFT;
            stop = int'(off) + BLOCK_BYTES;
            if (stop > piece_bytes)
                stop = piece_bytes;
            if (verified || off >= piece_bytes || off[BLOCK_SHIFT-1:0] != '0 ||
                blk >= MAX_BLOCKS || len != stop - off)
            begin
                due.status = ST_REJECTED;
            end
            else
            begin
                if (!active)
                begin
                    got_map = '0;
                    missing = CNT_W'(piece_blocks());
                    active  = 1'b1;
                end
                if (got_map[blk])
                    due.status = ST_DUPLICATE;
                else
                begin
                    got_map[blk] = 1'b1;
                    if (missing != 0)
                        missing--;
                    if (missing == 0)
                    begin
                        active     = 1'b0;
                        got_map    = '0;
                        due.status = ST_COMPLETE;
                    end
                    else
                        due.status = ST_ACCEPTED;
                end
            end
            due.remaining = active ? missing : '0;
            status_due.push_back(due);
        endfunction

        function void check_status(logic [OUT_W-1:0] word);
            block_status_t due;
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected status transfer, tdata %h", $time, word);
                return;
            end
            due = status_due.pop_front();
            if (word[STATUS_W-1:0] !== due.status)
            begin
                errors++;
                $display("%0t: status expected %0d, got %0d",
                         $time, due.status, word[STATUS_W-1:0]);
            end
            if (word[STATUS_W +: CNT_W] !== due.remaining)
            begin
                errors++;
                $display("%0t: remaining_blocks expected %0d, got %0d",
                         $time, due.remaining, word[STATUS_W +: CNT_W]);
            end
            if (word[OUT_W-1:STATUS_W+CNT_W] !== '0)
            begin
                errors++;
                $display("%0t: padding expected 0, got %h",
                         $time, word[OUT_W-1:STATUS_W+CNT_W]);
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    block_tracker_sb sb = new();
    int              blocks_sent = 0;
    bit              steady = 1'b0;

    piece_block_receive_tracker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
    end

    function automatic int unsigned block_len(int unsigned pb, int unsigned idx);
        int unsigned rest;
        rest = pb - idx * BLOCK_BYTES;
        return (rest > BLOCK_BYTES) ? BLOCK_BYTES : rest;
    endfunction

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_block(input logic [OFFSET_W-1:0] off, input logic [LENGTH_W-1:0] len);
        steady = (blocks_sent >= 400 && blocks_sent < 560);
        while (!steady && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, off};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_block(off, len);
        blocks_sent++;
    endtask

    // Malformed or out-of-range transfers around block idx of a piece of pb bytes.
    task automatic send_noise(input int unsigned pb, input int unsigned idx);
        logic [OFFSET_W-1:0] off;
        logic [LENGTH_W-1:0] len;
        case ($urandom_range(3))
            0:
            begin
                off = OFFSET_W'($urandom());
                len = LENGTH_W'($urandom());
            end
            1:
            begin
                off = OFFSET_W'($urandom_range(1023) << BLOCK_SHIFT);
                len = LENGTH_W'(BLOCK_BYTES);
            end
            2:
            begin
                off = OFFSET_W'((idx << BLOCK_SHIFT) | $urandom_range(BLOCK_BYTES - 1, 1));
                len = LENGTH_W'(block_len(pb, idx));
            end
            default:
            begin
                off = OFFSET_W'(idx << BLOCK_SHIFT);
                len = LENGTH_W'(block_len(pb, idx) ^ $urandom_range(16'hFFFF, 1));
            end
        endcase
        send_block(off, len);
    endtask

    // Stop sending and wait until every outstanding status has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic piece_round();
        int unsigned pb;
        int unsigned nblk;
        int unsigned pick;
        int unsigned j;
        int unsigned tmp;
        int unsigned order[MAX_BLOCKS];
        pick = $urandom_range(99);
        if (pick < 3)
            pb = MAX_BLOCKS * BLOCK_BYTES;
        else if (pick < 5)
            pb = $urandom_range(23'h7FFFFF, MAX_BLOCKS * BLOCK_BYTES + 1);
        else if (pick < 7)
            pb = $urandom() & 32'h7FFFFF;
        else if (pick < 9)
            pb = 0;
        else
            pb = $urandom_range(8 * BLOCK_BYTES, 1);
        settle();
        write_reg(REG_PIECE_VERIFIED, ($urandom_range(19) == 0));
        write_reg(REG_PIECE_BYTES, pb);
        nblk = (pb + BLOCK_BYTES - 1) >> BLOCK_SHIFT;
        if (nblk > MAX_BLOCKS)
            nblk = MAX_BLOCKS;
        for (int i = 0; i < nblk; i++)
            order[i] = i;
        for (int i = nblk - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // Now and then one block is held back, so the next piece starts while
        // tracking of this one is still active.
        if (nblk > 1 && $urandom_range(9) == 0)
            nblk--;
        if (nblk == 0)
        begin
            send_noise(pb, $urandom_range(3));
            send_noise(pb, $urandom_range(3));
        end
        for (int i = 0; i < nblk; i++)
        begin
            if ($urandom_range(99) < 8)
                send_noise(pb, order[$urandom_range(i)]);
            if (i > 0 && $urandom_range(99) < 8)
            begin
                j = order[$urandom_range(i - 1)];
                send_block(OFFSET_W'(j << BLOCK_SHIFT), LENGTH_W'(block_len(pb, j)));
            end
            send_block(OFFSET_W'(order[i] << BLOCK_SHIFT),
                       LENGTH_W'(block_len(pb, order[i])));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty piece: nothing can be accepted.
        send_block(0, 0);
        send_block(24'hFFFFFF, 16'hFFFF);
        settle();

        // One-byte piece completes on its only block, then starts over.
        write_reg(REG_PIECE_BYTES, 1);
        send_block(0, 1);
        send_block(0, 0);
        send_block(0, 1);
        settle();

        // Four blocks with a short last one.
        write_reg(REG_PIECE_BYTES, 3 * BLOCK_BYTES + 100);
        send_block(0, BLOCK_BYTES);
        send_block(0, BLOCK_BYTES);
        send_block(1, BLOCK_BYTES);
        send_block(3 * BLOCK_BYTES, BLOCK_BYTES);
        send_block(4 * BLOCK_BYTES, 100);
        send_block(3 * BLOCK_BYTES, 100);
        send_block(BLOCK_BYTES, BLOCK_BYTES);
        send_block(2 * BLOCK_BYTES, BLOCK_BYTES);
        settle();

        // The piece grows while tracking; the missing count stays as it was.
        write_reg(REG_PIECE_BYTES, 2 * BLOCK_BYTES);
        send_block(0, BLOCK_BYTES);
        settle();
        write_reg(REG_PIECE_BYTES, 4 * BLOCK_BYTES);
        send_block(3 * BLOCK_BYTES, BLOCK_BYTES);
        settle();

        write_reg(REG_PIECE_VERIFIED, 1);
        send_block(0, BLOCK_BYTES);
        settle();
        write_reg(REG_PIECE_VERIFIED, 0);

        // Largest register value: the block count is capped.
        write_reg(REG_PIECE_BYTES, 23'h7FFFFF);
        send_block(MAX_BLOCKS * BLOCK_BYTES, BLOCK_BYTES);
        send_block((MAX_BLOCKS - 1) * BLOCK_BYTES, BLOCK_BYTES);
        settle();
        write_reg(REG_PIECE_BYTES, MAX_BLOCKS * BLOCK_BYTES);
        send_block((MAX_BLOCKS - 1) * BLOCK_BYTES, BLOCK_BYTES);

        while (blocks_sent < 1020)
            piece_round();

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("piece_block_receive_tracker_unit_tb OK");
        else
            $display("piece_block_receive_tracker_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("piece_block_receive_tracker_unit_tb NOT OK");
        $finish;
    end

endmodule
